// File: src/content_defined_chunker_unit_macros.svh
//------------------------------------------------------------------------------
// Content-defined chunker assertion macros
// Concurrent assertion helpers shared by the chunker RTL.
//------------------------------------------------------------------------------
`ifndef CONTENT_DEFINED_CHUNKER_UNIT_MACROS_SVH
`define CONTENT_DEFINED_CHUNKER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CDCHK_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunker assertion failed");

// next-cycle implication, disabled during reset
`define CDCHK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunker assertion failed");

`endif

// File: src/cdchk_pkg.sv
//------------------------------------------------------------------------------
// Content-defined chunker package
// Shared constants, transaction types and register codes of the chunker.
//------------------------------------------------------------------------------
package cdchk_pkg;

   localparam int unsigned WindowBytes   = 8;
   localparam int unsigned WinBits       = WindowBytes * 8;
   localparam int unsigned LenBits       = 17;
   localparam int unsigned WinSizeBits   = 16;
   localparam int unsigned CsrAddrBits   = 3;
   localparam int unsigned CsrDataBits   = 32;
   localparam int unsigned QueueDepth    = 4;
   localparam int unsigned QueuePtrBits  = $clog2(QueueDepth);
   localparam int unsigned QueueCntBits  = $clog2(QueueDepth + 1);

   localparam logic [LenBits-1:0]     PosCap          = LenBits'(131071 - 1 - WindowBytes);
   localparam logic [WinSizeBits-1:0] WindowSizeReset = WinSizeBits'(1191);
   localparam logic [LenBits-1:0]     MaxChunkReset   = LenBits'(65536);

   typedef enum logic [0:0] {
      REG_WINDOW_SIZE = 1'b0,
      REG_SIZE_LIMIT  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [LenBits-1:0] chunk_length;
      logic               final_chunk;
   } rsp_type;

   typedef struct packed {
      logic [WinSizeBits-1:0] window_size;
      logic [LenBits-1:0]     size_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// File: src/cdchk_csr.sv
//------------------------------------------------------------------------------
// Chunker configuration registers
// APB-style register file holding the window size and the chunk size limit.
//------------------------------------------------------------------------------
module cdchk_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cdchk_pkg::CsrAddrBits-1:0]   paddr,
   input  logic [cdchk_pkg::CsrDataBits-1:0]   pwdata,
   output logic [cdchk_pkg::CsrDataBits-1:0]   prdata,
   output logic                                pready,
   output cdchk_pkg::cfg_type                  cfg
);

   cdchk_pkg::cfg_type       cfg_ff;
   cdchk_pkg::cfg_type       cfg_in;
   cdchk_pkg::reg_index_type reg_index;
   logic                     write_en;

   assign pready    = 1'b1;
   assign reg_index = cdchk_pkg::reg_index_type'(paddr[2]);
   assign write_en  = psel & penable & pwrite & pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (reg_index)
         cdchk_pkg::REG_WINDOW_SIZE: begin
            prdata = cdchk_pkg::CsrDataBits'(cfg_ff.window_size);
            if (write_en) begin
               cfg_in.window_size = pwdata[cdchk_pkg::WinSizeBits-1:0];
            end
         end
         cdchk_pkg::REG_SIZE_LIMIT: begin
            prdata = cdchk_pkg::CsrDataBits'(cfg_ff.size_limit);
            if (write_en) begin
               cfg_in.size_limit = pwdata[cdchk_pkg::LenBits-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size <= cdchk_pkg::WindowSizeReset;
         cfg_ff.size_limit  <= cdchk_pkg::MaxChunkReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/cdchk_outq.sv
//------------------------------------------------------------------------------
// Chunker result queue
// Small queue taking up to two results per cycle and releasing one per cycle.
//------------------------------------------------------------------------------
module cdchk_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  cdchk_pkg::push_type  push,
   input  logic                 pop,
   output cdchk_pkg::rsp_type   head,
   output logic                 not_empty,
   output logic                 almost_full
);

   cdchk_pkg::rsp_type                       entries_ff [cdchk_pkg::QueueDepth];
   logic [cdchk_pkg::QueuePtrBits-1:0]       wr_ptr_ff;
   logic [cdchk_pkg::QueuePtrBits-1:0]       wr_ptr_in;
   logic [cdchk_pkg::QueuePtrBits-1:0]       rd_ptr_ff;
   logic [cdchk_pkg::QueuePtrBits-1:0]       rd_ptr_in;
   logic [cdchk_pkg::QueueCntBits-1:0]       count_ff;
   logic [cdchk_pkg::QueueCntBits-1:0]       count_in;
   logic [cdchk_pkg::QueuePtrBits-1:0]       wr_ptr_next;

   assign head        = entries_ff[rd_ptr_ff];
   assign not_empty   = (count_ff != '0);
   assign almost_full = (count_ff > cdchk_pkg::QueueCntBits'(cdchk_pkg::QueueDepth - 2));
   assign wr_ptr_next = wr_ptr_ff + cdchk_pkg::QueuePtrBits'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + cdchk_pkg::QueuePtrBits'(push.count);
      rd_ptr_in = rd_ptr_ff + cdchk_pkg::QueuePtrBits'(pop);
      count_in  = count_ff + cdchk_pkg::QueueCntBits'(push.count)
                  - cdchk_pkg::QueueCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/content_defined_chunker_unit.sv
//------------------------------------------------------------------------------
// Content-defined chunker
// Asymmetric extremum chunking over a byte stream; emits chunk lengths.
//
//   channel | ports                   | direction | transaction
//   --------+-------------------------+-----------+---------------------------
//   req     | req_valid/req_stall     | in        | one stream byte, last flag
//   rsp     | rsp_valid/rsp_stall     | out       | one chunk length, final flag
//   csr     | csr_psel..csr_prdata    | in/out    | register write or read
//
// One byte is taken per cycle while req_stall is low; rsp is fed by the queue.
// The per-byte cost is one 64-bit compare against the held extreme.
// A byte with a boundary on its last flag yields two results, which the
// four-entry result queue drains one per cycle while rsp_stall is low.
// req_stall rises while the queue holds more than two results.
// Reset is synchronous; no clearing pass is needed.
//------------------------------------------------------------------------------
`include "content_defined_chunker_unit_macros.svh"

module content_defined_chunker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  cdchk_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output cdchk_pkg::rsp_type                  rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdchk_pkg::CsrAddrBits-1:0]   csr_paddr,
   input  logic [cdchk_pkg::CsrDataBits-1:0]   csr_pwdata,
   output logic [cdchk_pkg::CsrDataBits-1:0]   csr_prdata,
   output logic                                csr_pready
);

   cdchk_pkg::cfg_type                  cfg;
   cdchk_pkg::push_type                 push;
   logic                                accept;
   logic                                pop;
   logic                                queue_full;
   logic                                last_accept;
   logic                                stream_clear;

   logic [cdchk_pkg::WinBits-1:0]       byte_window_ff;
   logic [cdchk_pkg::WinBits-1:0]       byte_window_in;
   logic [cdchk_pkg::WinBits-1:0]       extreme_value_ff;
   logic [cdchk_pkg::WinBits-1:0]       extreme_value_in;
   logic [cdchk_pkg::LenBits-1:0]       extreme_position_ff;
   logic [cdchk_pkg::LenBits-1:0]       extreme_position_in;
   logic [cdchk_pkg::LenBits-1:0]       chunk_offset_ff;
   logic [cdchk_pkg::LenBits-1:0]       chunk_offset_in;

   logic [cdchk_pkg::WinBits-1:0]       window_next;
   logic [cdchk_pkg::LenBits:0]         count_sum;
   logic [cdchk_pkg::LenBits:0]         count;
   logic [cdchk_pkg::LenBits:0]         pos;
   logic [cdchk_pkg::LenBits:0]         pos_plus_one;
   logic [cdchk_pkg::LenBits:0]         window_end;
   logic [cdchk_pkg::LenBits-1:0]       limit;
   logic                                boundary;
   cdchk_pkg::rsp_type                  cut_rsp;
   cdchk_pkg::rsp_type                  end_rsp;

   cdchk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cdchk_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .pop         (pop),
      .head        (rsp_data),
      .not_empty   (rsp_valid),
      .almost_full (queue_full)
   );

   assign req_stall    = queue_full;
   assign accept       = req_valid & ~req_stall;
   assign pop          = rsp_valid & ~rsp_stall;
   assign last_accept  = accept & req_data.last_byte;
   assign stream_clear = (chunk_offset_ff == '0) && (extreme_value_ff == '0);

   always_comb begin
      window_next  = {byte_window_ff[cdchk_pkg::WinBits-9:0], req_data.data_byte};
      count_sum    = {1'b0, chunk_offset_ff} + (cdchk_pkg::LenBits+1)'(1);
      pos          = count_sum - (cdchk_pkg::LenBits+1)'(cdchk_pkg::WindowBytes);
      pos_plus_one = pos + (cdchk_pkg::LenBits+1)'(1);
      window_end   = {1'b0, extreme_position_ff}
                     + (cdchk_pkg::LenBits+1)'(cfg.window_size);
      if ((cfg.size_limit == '0) || (cfg.size_limit > cdchk_pkg::PosCap)) begin
         limit = cdchk_pkg::PosCap;
      end else begin
         limit = cfg.size_limit;
      end

      byte_window_in      = byte_window_ff;
      extreme_value_in    = extreme_value_ff;
      extreme_position_in = extreme_position_ff;
      count               = count_sum;
      boundary            = 1'b0;

      if (count_sum >= (cdchk_pkg::LenBits+1)'(cdchk_pkg::WindowBytes)) begin
         if (pos == '0) begin
            extreme_value_in    = window_next;
            extreme_position_in = '0;
         end else if (window_next > extreme_value_ff) begin
            extreme_value_in    = window_next;
            extreme_position_in = pos[cdchk_pkg::LenBits-1:0];
         end else if ((pos == window_end) || (pos >= {1'b0, limit})) begin
            boundary            = 1'b1;
            count               = (cdchk_pkg::LenBits+1)'(cdchk_pkg::WindowBytes - 1);
            extreme_value_in    = '0;
            extreme_position_in = '0;
         end
      end
      byte_window_in  = window_next;
      chunk_offset_in = count[cdchk_pkg::LenBits-1:0];

      cut_rsp.chunk_length = pos_plus_one[cdchk_pkg::LenBits-1:0];
      cut_rsp.final_chunk  = 1'b0;
      end_rsp.chunk_length = chunk_offset_in;
      end_rsp.final_chunk  = 1'b1;

      push = '0;
      if (boundary && req_data.last_byte) begin
         push.count  = 2'd2;
         push.first  = cut_rsp;
         push.second = end_rsp;
      end else if (boundary) begin
         push.count = 2'd1;
         push.first = cut_rsp;
      end else if (req_data.last_byte) begin
         push.count = 2'd1;
         push.first = end_rsp;
      end

      if (req_data.last_byte) begin
         byte_window_in      = '0;
         extreme_value_in    = '0;
         extreme_position_in = '0;
         chunk_offset_in     = '0;
      end

      if (!accept) begin
         push                = '0;
         byte_window_in      = byte_window_ff;
         extreme_value_in    = extreme_value_ff;
         extreme_position_in = extreme_position_ff;
         chunk_offset_in     = chunk_offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_window_ff      <= '0;
         extreme_value_ff    <= '0;
         extreme_position_ff <= '0;
         chunk_offset_ff     <= '0;
      end else begin
         byte_window_ff      <= byte_window_in;
         extreme_value_ff    <= extreme_value_in;
         extreme_position_ff <= extreme_position_in;
         chunk_offset_ff     <= chunk_offset_in;
      end
   end

   `CDCHK_ASSERT_SAME(a_extreme_in_chunk, clock, reset, 1'b1, extreme_position_ff <= chunk_offset_ff)
   `CDCHK_ASSERT_NEXT(a_last_clears, clock, reset, last_accept, stream_clear)
   `CDCHK_ASSERT_NEXT(a_last_emits, clock, reset, last_accept, rsp_valid)

endmodule

// File: bench/tb.sv
//------------------------------------------------------------------------------
// Content-defined chunker testbench
// Streams bytes into the chunker and checks every chunk length against a
// local predictor of the extremum chunking rule. Covers register extremes,
// size and window cuts, ties, boundary-with-last, mid-chunk register changes,
// back-pressure and long random streams with random idle on both channels.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   typedef enum logic [1:0] {
      PAT_RANDOM,
      PAT_FLAT,
      PAT_RISING,
      PAT_SPARSE
   } pattern_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_valid   = 1'b0;
   logic                                 req_stall;
   cdchk_pkg::req_type                   req_data    = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall   = 1'b0;
   cdchk_pkg::rsp_type                   rsp_data;
   logic                                 csr_psel    = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite  = 1'b0;
   logic [cdchk_pkg::CsrAddrBits-1:0]    csr_paddr   = '0;
   logic [cdchk_pkg::CsrDataBits-1:0]    csr_pwdata  = '0;
   logic [cdchk_pkg::CsrDataBits-1:0]    csr_prdata;
   logic                                 csr_pready;

   bit                                   idle_on     = 1'b1;
   int unsigned                          rsp_hold    = 0;
   int unsigned                          errors      = 0;

   // predictor state and register copies
   logic [cdchk_pkg::WinBits-1:0]        win_bytes;
   logic [cdchk_pkg::WinBits-1:0]        peak_value;
   logic [cdchk_pkg::LenBits-1:0]        peak_pos;
   logic [cdchk_pkg::LenBits-1:0]        chunk_fill;
   logic [cdchk_pkg::WinSizeBits-1:0]    cfg_window;
   logic [cdchk_pkg::LenBits-1:0]        cfg_max;
   cdchk_pkg::rsp_type                   pending_chunks[$];

   content_defined_chunker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[content_defined_chunker_unit] ERROR");
      $finish;
   end

   function automatic void advance_chunker(input cdchk_pkg::req_type t);
      int unsigned        count;
      int unsigned        limit;
      int unsigned        p;
      cdchk_pkg::rsp_type r;
      limit = cfg_max;
      if (limit == 0 || limit > cdchk_pkg::PosCap) begin
         limit = cdchk_pkg::PosCap;
      end
      win_bytes = {win_bytes[cdchk_pkg::WinBits-9:0], t.data_byte};
      count = chunk_fill + 1;
      if (count >= cdchk_pkg::WindowBytes) begin
         p = count - cdchk_pkg::WindowBytes;
         if (p == 0) begin
            peak_value = win_bytes;
            peak_pos   = '0;
         end else if (win_bytes > peak_value) begin
            peak_value = win_bytes;
            peak_pos   = cdchk_pkg::LenBits'(p);
         end else if (p == int'(peak_pos) + int'(cfg_window) || p >= limit) begin
            r.chunk_length = cdchk_pkg::LenBits'(p + 1);
            r.final_chunk  = 1'b0;
            pending_chunks.push_back(r);
            count      = cdchk_pkg::WindowBytes - 1;
            peak_value = '0;
            peak_pos   = '0;
         end
      end
      chunk_fill = cdchk_pkg::LenBits'(count);
      if (t.last_byte) begin
         r.chunk_length = chunk_fill;
         r.final_chunk  = 1'b1;
         pending_chunks.push_back(r);
         win_bytes  = '0;
         peak_value = '0;
         peak_pos   = '0;
         chunk_fill = '0;
      end
   endfunction

   function automatic logic [7:0] pattern_byte(input pattern_type pat, input logic [7:0] seed,
                                               input int unsigned idx);
      case (pat)
         PAT_FLAT:   return seed;
         PAT_RISING: return seed + 8'(idx);
         PAT_SPARSE: return 8'($urandom_range(0, 3));
         default:    return 8'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int unsigned        gap;
      cdchk_pkg::req_type t;
      t.data_byte = b;
      t.last_byte = lst;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      advance_chunker(t);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input cdchk_pkg::reg_index_type idx,
                            input logic [cdchk_pkg::CsrDataBits-1:0] val);
      logic [cdchk_pkg::CsrDataBits-1:0] held;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= cdchk_pkg::CsrAddrBits'(int'(idx) * 4);
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == cdchk_pkg::REG_WINDOW_SIZE) begin
         cfg_window = val[cdchk_pkg::WinSizeBits-1:0];
         held       = cdchk_pkg::CsrDataBits'(cfg_window);
      end else begin
         cfg_max = val[cdchk_pkg::LenBits-1:0];
         held    = cdchk_pkg::CsrDataBits'(cfg_max);
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== held) begin
         $error("register %s: expected %0h, got %0h", idx.name(), held, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_run(input int unsigned n, input pattern_type pat, input logic [7:0] seed,
                           input bit end_stream);
      for (int unsigned i = 0; i < n; i++) begin
         send_byte(pattern_byte(pat, seed, i), end_stream && i == n - 1);
      end
   endtask

   // reset settings, then clamped size limits with a window that never matches
   task automatic test_size_limits();
      send_run(200, PAT_FLAT, 8'h00, 1'b1);
      wait_idle();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'h0);
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'h0);
      send_run(40, PAT_FLAT, 8'h00, 1'b1);
      wait_idle();
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'h1FFFF);
      send_run(40, PAT_FLAT, 8'hA5, 1'b1);
      wait_idle();
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd8);
      send_run(20, PAT_FLAT, 8'hFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_directed_cases();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'hFFFF);
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd65536);
      send_byte(8'hFF, 1'b1);
      send_run(7, PAT_FLAT, 8'h00, 1'b1);
      wait_idle();
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd8);
      send_run(12, PAT_FLAT, 8'hFF, 1'b1);
      wait_idle();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd1);
      // tie is not a new extreme; boundary and end of stream on one byte
      send_run(9, PAT_FLAT, 8'h00, 1'b1);
      send_run(14, PAT_RISING, 8'h01, 1'b1);
      wait_idle();
      // new extreme exactly at the size limit
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd0);
      send_run(15, PAT_FLAT, 8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_run(8, PAT_FLAT, 8'h00, 1'b1);
      wait_idle();
   endtask

   task automatic test_midchunk_config();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd30);
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd2000);
      send_run(40, PAT_RISING, 8'h01, 1'b0);
      send_run(10, PAT_FLAT, 8'h00, 1'b0);
      wait_idle();
      // lowered limit cuts at once
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd8);
      send_run(5, PAT_FLAT, 8'h00, 1'b0);
      wait_idle();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd50);
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd2000);
      send_run(20, PAT_RISING, 8'h10, 1'b0);
      send_run(30, PAT_FLAT, 8'h00, 1'b0);
      wait_idle();
      // lowered window is passed over
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd5);
      send_run(20, PAT_FLAT, 8'h00, 1'b0);
      send_run(30, PAT_RANDOM, 8'h00, 1'b1);
      wait_idle();
   endtask

   task automatic test_backpressure();
      write_reg(cdchk_pkg::REG_WINDOW_SIZE, 32'd1);
      write_reg(cdchk_pkg::REG_SIZE_LIMIT, 32'd8);
      idle_on  = 1'b1;
      rsp_hold = 200;
      send_run(80, PAT_SPARSE, 8'h00, 1'b0);
      // hold the sender until everything has drained
      wait_idle();
      send_run(40, PAT_RANDOM, 8'h00, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_streams(input int unsigned total);
      int unsigned sent;
      int unsigned phase_end;
      int unsigned run;
      pattern_type pat;
      logic [7:0]  seed;
      logic        lst;
      logic [31:0] win_val;
      logic [31:0] max_val;
      sent = 0;
      while (sent < total) begin
         wait_idle();
         case ($urandom_range(0, 9))
            0:       win_val = 32'd0;
            1:       win_val = $urandom;
            2:       win_val = $urandom_range(0, 1) ? 32'hFFFF : 32'd1;
            default: win_val = $urandom_range(1, 40);
         endcase
         case ($urandom_range(0, 9))
            0:       max_val = 32'd0;
            1:       max_val = $urandom;
            2:       max_val = $urandom_range(0, 1) ? 32'h1FFFF : 32'd8;
            default: max_val = $urandom_range(8, 400);
         endcase
         write_reg(cdchk_pkg::REG_WINDOW_SIZE, win_val);
         write_reg(cdchk_pkg::REG_SIZE_LIMIT, max_val);
         idle_on   = $urandom_range(0, 3) != 0;
         phase_end = sent + $urandom_range(100, 200);
         while (sent < phase_end && sent < total) begin
            run  = $urandom_range(1, 120);
            pat  = pattern_type'($urandom_range(0, 3));
            seed = 8'($urandom);
            for (int unsigned i = 0; i < run; i++) begin
               if (i == run - 1) begin
                  lst = $urandom_range(0, 4) != 0;
               end else begin
                  lst = $urandom_range(0, 99) == 0;
               end
               send_byte(pattern_byte(pat, seed, i), lst);
               sent++;
            end
         end
      end
      wait_idle();
   endtask

   initial begin : rsp_side
      int unsigned hold;
      @(posedge clock);
      forever begin
         if (rsp_hold != 0) begin
            hold     = rsp_hold;
            rsp_hold = 0;
         end else begin
            hold = idle_on ? $urandom_range(0, 3) : 0;
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      cdchk_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chunks.size() == 0) begin
            $error("unexpected chunk: length %0d final %0d",
                   rsp_data.chunk_length, rsp_data.final_chunk);
            errors++;
         end else begin
            want = pending_chunks.pop_front();
            if (rsp_data.chunk_length !== want.chunk_length) begin
               $error("chunk_length: expected %0d, got %0d",
                      want.chunk_length, rsp_data.chunk_length);
               errors++;
            end
            if (rsp_data.final_chunk !== want.final_chunk) begin
               $error("final_chunk: expected %0d, got %0d",
                      want.final_chunk, rsp_data.final_chunk);
               errors++;
            end
         end
      end
   end

   initial begin
      int unsigned k;
      win_bytes  = '0;
      peak_value = '0;
      peak_pos   = '0;
      chunk_fill = '0;
      cfg_window = cdchk_pkg::WindowSizeReset;
      cfg_max    = cdchk_pkg::MaxChunkReset;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_size_limits();
      test_directed_cases();
      test_midchunk_config();
      test_backpressure();
      test_random_streams(1000);
      req_valid <= 1'b0;
      for (k = 0; k < 20000 && pending_chunks.size() != 0; k++) @(posedge clock);
      if (pending_chunks.size() != 0) begin
         $error("%0d chunks never arrived", pending_chunks.size());
         errors++;
      end
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("[content_defined_chunker_unit] OK");
      end else begin
         $display("[content_defined_chunker_unit] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/cdchk_pkg.sv
src/cdchk_csr.sv
src/cdchk_outq.sv
src/content_defined_chunker_unit.sv
bench/tb.sv
